### hdl/bmean_pkg.sv
package bmean_pkg;

  localparam int GRID_SIDE_W = 11;
  localparam logic [GRID_SIDE_W-1:0] GRID_SIDE_RESET = 11'd16;

  typedef enum logic {
    REQ_CELL  = 1'b0,
    REQ_DRAIN = 1'b1
  } req_t;

  // Which sides of the 3x3 window fall off the grid for one result.
  typedef struct packed {
    logic off_left;
    logic off_right;
    logic off_top;
    logic off_bottom;
  } edge_t;

endpackage

### hdl/box_mean_3x3_grid_pass.sv
// 3x3 box mean over a square grid streamed in row-major order.
//
// Input channel (in_valid/in_ready): each transfer carries req_type and
// cell_value. Cells of one frame come first, grid_side * grid_side of them;
// then drain requests flush the last row plus one result. A cell sent while
// results are still pending and a drain sent mid-frame are taken and dropped.
// Output channel (out_valid/out_ready): mean_value and frame_last, one result
// for every grid cell, in row-major order, frame_last on the final one.
// A result lags its cell by grid_side + 1 input transfers; after the transfer
// that releases it, it moves through p1, p2 and p3 into the output register.
// Throughput is one transfer per cycle while the skid stage is empty, set by
// the single line RAM, read and written once per cell, with a same-entry bypass.
// A one-entry skid stage sits behind the output register: while the receiver
// stalls, in_ready stays high until the skid holds a result, then drops.
// Writing grid_side (cfg_we) restarts the frame; do it only while idle.
// Reset sets grid_side to 16 and clears the position counters and the
// pipeline; the line RAM needs no clearing pass, since entries not yet
// written only ever feed neighbours that lie off the grid.
module box_mean_3x3_grid_pass
  import bmean_pkg::*;
#(
  parameter int MAX_SIDE    = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [GRID_SIDE_W-1:0] cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   req_type,
  input  logic [SAMPLE_BITS-1:0] cell_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] mean_value,
  output logic                   frame_last
);

  localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CW = $clog2(MAX_SIDE + 1);
  localparam int XW = (CW > GRID_SIDE_W) ? CW : GRID_SIDE_W;
  localparam int SW = SAMPLE_BITS + 4;
  localparam int DK = SW + 3;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << DK) + 64'd8) / 64'd9;
  localparam logic [SW-1:0] RECIP = RECIP_FULL[SW-1:0];

  logic [GRID_SIDE_W-1:0] grid_side;
  logic [XW-1:0]          gs_ext;
  logic [CW-1:0]          side_n;
  logic [CW-1:0]          n_minus1;

  logic [CW-1:0] in_row, in_col, out_row, out_col;
  logic [CW-1:0] in_row_next, in_col_next, out_row_next, out_col_next;

  logic  adv, acc, is_cell, cell_ok, drain_ok, col_end, emit_now, last_now;
  edge_t edge_now;

  logic                   rd_en, wr_en;
  logic [2*SAMPLE_BITS-1:0] line_rd, line_wr;

  logic                   p1_valid, p1_cell, p1_zero, p1_emit, p1_last;
  logic [SAMPLE_BITS-1:0] p1_value;
  logic [AW-1:0]          p1_addr;
  edge_t                  p1_edge;

  logic [SAMPLE_BITS-1:0] col_top, col_mid, col_bot;
  logic [SAMPLE_BITS-1:0] win [3][3];

  logic                   p2_valid, p2_last;
  edge_t                  p2_edge;
  logic [SW-1:0]          sum_acc;

  logic                   p3_valid, p3_last;
  logic [SW-1:0]          p3_sum;
  logic [2*SW-1:0]        prod;
  logic [SAMPLE_BITS-1:0] quot;

  logic                   skid_valid, skid_last;
  logic [SAMPLE_BITS-1:0] skid_mean;

  // Grid side as used: zero acts as one, anything above MAX_SIDE as MAX_SIDE.
  always_comb begin
    gs_ext = XW'(grid_side);
    if (gs_ext == '0) begin
      side_n = CW'(1);
    end else if (gs_ext > XW'(MAX_SIDE)) begin
      side_n = CW'(MAX_SIDE);
    end else begin
      side_n = CW'(gs_ext);
    end
  end
  assign n_minus1 = side_n - CW'(1);

  assign adv      = !skid_valid;
  assign in_ready = adv;
  assign acc      = in_valid && in_ready;

  always_comb begin
    is_cell  = (req_t'(req_type) == REQ_CELL);
    cell_ok  = is_cell && (in_row < side_n);
    drain_ok = !is_cell && (in_row >= side_n);
    col_end  = (in_col == side_n);
    if (cell_ok) begin
      emit_now = (in_row > CW'(1)) || ((in_row == CW'(1)) && (in_col != '0));
    end else if (drain_ok) begin
      emit_now = (side_n != CW'(1)) || (in_col != '0);
    end else begin
      emit_now = 1'b0;
    end
    last_now            = (out_row == n_minus1) && (out_col == n_minus1);
    edge_now.off_left   = (out_col == '0);
    edge_now.off_right  = (out_col == n_minus1);
    edge_now.off_top    = (out_row == '0);
    edge_now.off_bottom = (out_row == n_minus1);
  end

  always_comb begin
    in_row_next  = in_row;
    in_col_next  = in_col;
    out_row_next = out_row;
    out_col_next = out_col;
    if (cell_ok) begin
      if (in_col == n_minus1) begin
        in_col_next = '0;
        in_row_next = in_row + CW'(1);
      end else begin
        in_col_next = in_col + CW'(1);
      end
    end else if (drain_ok) begin
      in_col_next = in_col + CW'(1);
    end
    if (emit_now) begin
      if (last_now) begin
        in_row_next  = '0;
        in_col_next  = '0;
        out_row_next = '0;
        out_col_next = '0;
      end else if (out_col == n_minus1) begin
        out_col_next = '0;
        out_row_next = out_row + CW'(1);
      end else begin
        out_col_next = out_col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= GRID_SIDE_RESET;
      in_row    <= '0;
      in_col    <= '0;
      out_row   <= '0;
      out_col   <= '0;
    end else if (cfg_we) begin
      grid_side <= cfg_wdata;
      in_row    <= '0;
      in_col    <= '0;
      out_row   <= '0;
      out_col   <= '0;
    end else if (acc) begin
      in_row  <= in_row_next;
      in_col  <= in_col_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
    end
  end

  // Each line RAM word holds the two rows above the incoming one at a column.
  assign rd_en   = acc && (cell_ok || (drain_ok && !col_end));
  assign wr_en   = adv && p1_valid && p1_cell;
  assign line_wr = {line_rd[SAMPLE_BITS-1:0], p1_value};

  bmean_line_ram #(
    .DEPTH (MAX_SIDE),
    .AW    (AW),
    .DW    (2 * SAMPLE_BITS)
  ) u_line_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (in_col[AW-1:0]),
    .rd_data (line_rd),
    .wr_en   (wr_en),
    .wr_addr (p1_addr),
    .wr_data (line_wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= acc && (cell_ok || drain_ok);
      p2_valid <= p1_valid && p1_emit;
      p3_valid <= p2_valid;
    end
  end

  always_comb begin
    col_top = p1_zero ? '0 : line_rd[2*SAMPLE_BITS-1:SAMPLE_BITS];
    col_mid = p1_zero ? '0 : line_rd[SAMPLE_BITS-1:0];
    col_bot = p1_cell ? p1_value : '0;
  end

  always_comb begin
    sum_acc = '0;
    for (int dc = 0; dc < 3; dc++) begin
      for (int dr = 0; dr < 3; dr++) begin
        logic off_grid;
        off_grid = (dc == 0 && p2_edge.off_left) || (dc == 2 && p2_edge.off_right) ||
                   (dr == 0 && p2_edge.off_top) || (dr == 2 && p2_edge.off_bottom);
        sum_acc = sum_acc + SW'(off_grid ? win[1][1] : win[dc][dr]);
      end
    end
  end

  // Divide by nine through the reciprocal; exact for every sum of nine samples.
  assign prod = (2*SW)'(p3_sum) * (2*SW)'(RECIP);
  assign quot = prod[DK +: SAMPLE_BITS];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (acc) begin
        p1_cell  <= cell_ok;
        p1_zero  <= drain_ok && col_end;
        p1_emit  <= emit_now;
        p1_last  <= last_now;
        p1_edge  <= edge_now;
        p1_value <= cell_value;
        p1_addr  <= in_col[AW-1:0];
      end
      if (p1_valid) begin
        for (int r = 0; r < 3; r++) begin
          win[0][r] <= win[1][r];
          win[1][r] <= win[2][r];
        end
        win[2][0] <= col_top;
        win[2][1] <= col_mid;
        win[2][2] <= col_bot;
      end
      p2_edge <= p1_edge;
      p2_last <= p1_last;
      p3_sum  <= sum_acc;
      p3_last <= p2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (out_valid && !out_ready) begin
      if (p3_valid) begin
        skid_valid <= 1'b1;
      end
    end else begin
      out_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        mean_value <= skid_mean;
        frame_last <= skid_last;
      end
    end else if (out_valid && !out_ready) begin
      if (p3_valid) begin
        skid_mean <= quot;
        skid_last <= p3_last;
      end
    end else if (p3_valid) begin
      mean_value <= quot;
      frame_last <= p3_last;
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while the output register is empty");

  a_in_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (in_row <= side_n) && (in_col <= side_n))
    else $error("input position beyond the grid");

  a_out_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (out_row < side_n) && (out_col < side_n))
    else $error("result position beyond the grid");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (acc && emit_now && last_now) |=>
      ((in_row == '0) && (in_col == '0) && (out_row == '0) && (out_col == '0)))
    else $error("counters not cleared after the final result of a frame");
`endif

endmodule

### hdl/bmean_line_ram.sv
module bmean_line_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] mem_q;
  logic [DW-1:0] fwd_data;
  logic          fwd_hit;

  // The array returns the old word when a read and a write meet at one entry
  // on the same edge, so the written word is captured and used instead.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      fwd_hit  <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  assign rd_data = fwd_hit ? fwd_data : mem_q;

endmodule

### tb/sv/tb_top.sv
module tb_top;
  import bmean_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SIDE      = 1024;
  localparam int SAMPLE_BITS   = 16;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 520;
  localparam int DRAIN_LIMIT   = 100000;

  typedef struct packed {
    logic [15:0] mean;
    logic        is_last;
  } smooth_res_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [GRID_SIDE_W-1:0] cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  req_t                   req_type = REQ_CELL;
  logic [SAMPLE_BITS-1:0] cell_value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SAMPLE_BITS-1:0] mean_value;
  logic                   frame_last;

  // Predicted state of the block.
  logic [GRID_SIDE_W-1:0] side_cfg;
  logic [15:0]            upper_row [MAX_SIDE];
  logic [15:0]            middle_row [MAX_SIDE];
  logic [15:0]            win [3][3];  // [column: oldest..newest][row: top..bottom]
  int unsigned            row_pos;
  int unsigned            col_pos;
  int unsigned            out_idx;

  smooth_res_t pending_means[$];
  int unsigned errors = 0;
  int unsigned used_items = 0;
  int unsigned send_burst = 0;
  int unsigned recv_burst = 0;
  int unsigned hold_left = 0;

  box_mean_3x3_grid_pass #(
    .MAX_SIDE   (MAX_SIDE),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .cell_value(cell_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mean_value(mean_value),
    .frame_last(frame_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("box_mean_3x3_grid_pass verification failed");
    $finish;
  end

  // Mostly short gaps, a few long ones, and now and then a burst with none.
  function automatic int unsigned idle_len(inout int unsigned burst);
    int unsigned r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 4) begin
      burst = $urandom_range(80, 20);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic int unsigned grid_n();
    int unsigned s;
    s = 32'(side_cfg);
    if (s == 0) return 1;
    if (s > MAX_SIDE) return MAX_SIDE;
    return s;
  endfunction

  function automatic void restart_frame();
    row_pos = 0;
    col_pos = 0;
    out_idx = 0;
  endfunction

  function automatic void reset_model();
    side_cfg = GRID_SIDE_RESET;
    for (int i = 0; i < MAX_SIDE; i++) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        win[c][r] = '0;
      end
    end
    restart_frame();
  endfunction

  function automatic void shift_window(logic [15:0] top, logic [15:0] mid, logic [15:0] bot);
    for (int r = 0; r < 3; r++) begin
      win[0][r] = win[1][r];
      win[1][r] = win[2][r];
    end
    win[2][0] = top;
    win[2][1] = mid;
    win[2][2] = bot;
  endfunction

  // Neighbours that fall off the grid take the centre value.
  function automatic void emit_mean();
    int unsigned n;
    int unsigned rc;
    int unsigned cc;
    int unsigned sum;
    logic [15:0] centre;
    bit off_col;
    bit off_row;
    smooth_res_t res;
    n = grid_n();
    rc = out_idx / n;
    cc = out_idx % n;
    centre = win[1][1];
    sum = 0;
    for (int dc = 0; dc < 3; dc++) begin
      for (int dr = 0; dr < 3; dr++) begin
        off_col = (dc == 0 && cc == 0) || (dc == 2 && cc == n - 1);
        off_row = (dr == 0 && rc == 0) || (dr == 2 && rc == n - 1);
        sum += 32'((off_col || off_row) ? centre : win[dc][dr]);
      end
    end
    res.mean = 16'(sum / 9);
    res.is_last = (out_idx == n * n - 1);
    pending_means.push_back(res);
    out_idx++;
    if (res.is_last) restart_frame();
  endfunction

  // Returns 1 when the item is part of the frame or its flush, 0 when dropped.
  function automatic bit smooth_step(req_t kind, logic [15:0] value);
    int unsigned n;
    int unsigned c;
    int unsigned k;
    logic [15:0] a;
    logic [15:0] b;
    n = grid_n();
    c = col_pos;
    if (kind == REQ_CELL) begin
      if (row_pos >= n || c >= n) return 0;
      a = upper_row[c];
      b = middle_row[c];
      upper_row[c] = b;
      middle_row[c] = value;
      shift_window(a, b, value);
      k = row_pos * n + c;
      col_pos = c + 1;
      if (col_pos >= n) begin
        col_pos = 0;
        row_pos++;
      end
    end else begin
      if (row_pos < n) return 0;
      if (c < n) shift_window(upper_row[c], middle_row[c], '0);
      else shift_window('0, '0, '0);
      k = n * n + c;
      col_pos = c + 1;
    end
    if (k >= n + 1) emit_mean();
    return 1;
  endfunction

  // Called at a rising edge; valid stays high after the transfer so that a
  // following item can go out in the next cycle.
  task automatic send_req(input req_t kind, input logic [15:0] value);
    int unsigned gap;
    gap = idle_len(send_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    cell_value <= value;
    do @(posedge clk); while (!in_ready);
    if (smooth_step(kind, value)) used_items++;
  endtask

  task automatic write_side(input logic [GRID_SIDE_W-1:0] side);
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= side;
    @(posedge clk);
    cfg_we <= 1'b0;
    side_cfg = side;
    restart_frame();
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      hold_left = idle_len(recv_burst);
    end
  end

  always @(posedge clk) begin : check_means
    smooth_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_means.size() == 0) begin
        if (errors < 100)
          $display("%0t: unexpected result, mean_value=%h frame_last=%b",
                   $time, mean_value, frame_last);
        errors++;
      end else begin
        want = pending_means.pop_front();
        if (mean_value !== want.mean) begin
          if (errors < 100)
            $display("%0t: mean_value expected %h actual %h", $time, want.mean, mean_value);
          errors++;
        end
        if (frame_last !== want.is_last) begin
          if (errors < 100)
            $display("%0t: frame_last expected %b actual %b", $time, want.is_last, frame_last);
          errors++;
        end
      end
    end
  end

  // The side after reset must be 16; the partial frame is then cut short by
  // the register write of the next test, which restarts the frame.
  task automatic test_default_side();
    repeat (18) send_req(REQ_CELL, 16'($urandom));
  endtask

  task automatic test_tiny_grids();
    write_side(GRID_SIDE_W'(2));
    send_req(REQ_CELL, 16'hFFFF);
    send_req(REQ_CELL, 16'h0001);
    send_req(REQ_DRAIN, 16'h1234);  // mid-frame drain is ignored
    send_req(REQ_CELL, 16'h8000);
    send_req(REQ_CELL, 16'hFFFF);
    send_req(REQ_CELL, 16'h7FFF);   // results still pending, so dropped
    repeat (3) send_req(REQ_DRAIN, 16'h0000);
    send_req(REQ_DRAIN, 16'hFFFF);  // frame already closed
    // A side of zero behaves as a single cell; its first drain gives nothing.
    write_side(GRID_SIDE_W'(0));
    send_req(REQ_DRAIN, 16'hFFFF);
    send_req(REQ_CELL, 16'hFFFF);
    send_req(REQ_CELL, 16'h0000);
    send_req(REQ_DRAIN, 16'h0000);
    send_req(REQ_DRAIN, 16'h0000);
    write_side(GRID_SIDE_W'(1));
    send_req(REQ_CELL, 16'h0000);
    send_req(REQ_DRAIN, 16'hFFFF);
    send_req(REQ_DRAIN, 16'hFFFF);
    send_req(REQ_CELL, 16'h5A5A);
    send_req(REQ_DRAIN, 16'h0000);
    send_req(REQ_DRAIN, 16'h0000);
  endtask

  // Full-size frames would take a million cells, so only the first rows go in.
  // An oversized side clamps to the widest grid.
  task automatic test_widest_sides();
    write_side('1);
    repeat (MAX_SIDE + 4) send_req(REQ_CELL, 16'($urandom));
  endtask

  function automatic logic [15:0] pick_value(int unsigned mode);
    case (mode)
      0: return 16'($urandom);
      1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(65535, 65000));
    endcase
  endfunction

  task automatic test_random_frames();
    int unsigned start;
    int unsigned n;
    int unsigned eff;
    int unsigned r;
    int unsigned mode;
    int unsigned cut;
    bit need_write;
    start = used_items;
    need_write = 1'b1;
    n = 1;
    while (used_items - start < RANDOM_ITEMS) begin
      if (need_write || $urandom_range(2) == 0) begin
        r = $urandom_range(99);
        if (r < 2) n = 0;
        else if (r < 70) n = $urandom_range(6, 1);
        else if (r < 93) n = $urandom_range(20, 7);
        else n = $urandom_range(40, 21);
        write_side(GRID_SIDE_W'(n));
        need_write = 1'b0;
      end
      eff = (n == 0) ? 1 : n;
      mode = $urandom_range(2);
      cut = ($urandom_range(19) == 0) ? $urandom_range(eff * eff - 1) : eff * eff;
      for (int unsigned i = 0; i < cut; i++) begin
        if ($urandom_range(31) == 0) send_req(REQ_DRAIN, 16'($urandom));
        send_req(REQ_CELL, pick_value(mode));
      end
      if (cut < eff * eff) begin
        // Abandoned frame: only a register write brings the block back.
        need_write = 1'b1;
        continue;
      end
      for (int unsigned i = 0; i <= eff; i++) begin
        if ($urandom_range(15) == 0) send_req(REQ_CELL, 16'($urandom));
        send_req(REQ_DRAIN, 16'($urandom));
      end
      if ($urandom_range(7) == 0) send_req(REQ_DRAIN, 16'($urandom));
    end
  endtask

  initial begin
    int unsigned waited;
    reset_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_default_side();
    test_tiny_grids();
    test_widest_sides();
    test_random_frames();
    in_valid <= 1'b0;
    waited = 0;
    while (pending_means.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_means.size() != 0) begin
      $display("%0t: %0d expected results never arrived, next mean_value expected %h",
               $time, pending_means.size(), pending_means[0].mean);
      errors += pending_means.size();
    end
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("box_mean_3x3_grid_pass verification clean");
    end else begin
      $display("box_mean_3x3_grid_pass verification failed");
    end
    $finish;
  end

endmodule

### box_mean_3x3_grid_pass.f
hdl/bmean_pkg.sv
hdl/bmean_line_ram.sv
hdl/box_mean_3x3_grid_pass.sv
tb/sv/tb_top.sv
